[src/ba_pkg.sv]
package ba_pkg;

   localparam int NUM_SLOTS_DEF = 512;
   localparam int MIN_BLOCK_DEF = 32;
   localparam int MAX_BLOCK_DEF = 16384;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index of the heap base address.
   localparam logic [0:0] REG_HEAP_BASE = 1'b0;

   localparam logic [0:0] OP_ALLOC = 1'b0;
   localparam logic [0:0] OP_FREE  = 1'b1;

   localparam logic [31:0] HEAP_BASE_RESET = 32'h2000_1000;

   typedef enum logic [3:0] {
      ST_CLR,
      ST_IDLE,
      ST_A_DESC,
      ST_A_LEAF,
      ST_A_UNW,
      ST_A_FIX,
      ST_F_CHK,
      ST_M_SIZE,
      ST_M_PAR,
      ST_M_BUD,
      ST_M_W2,
      ST_M_RD,
      ST_DONE
   } state_type;

endpackage

[src/ba_req_if.sv]
interface ba_req_if;
   logic        valid;
   logic        ready;
   logic [0:0]  req_type;
   logic [15:0] req_size;
   logic [31:0] free_address;

   modport source (output valid, output req_type, output req_size, output free_address,
                   input ready);
   modport sink (input valid, input req_type, input req_size, input free_address,
                 output ready);
endinterface

[src/ba_rsp_if.sv]
interface ba_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [31:0] block_address;

   modport source (output valid, output ok, output block_address, input ready);
   modport sink (input valid, input ok, input block_address, output ready);
endinterface

[src/buddy_allocator_core.sv]
// Buddy allocator over a heap of NUM_SLOTS slots of MIN_BLOCK bytes (MIN_BLOCK a power of two).
// Each slot has one entry in a table memory with one write and one read port, holding the size
// of the block that starts there and a used bit. After reset a clearing pass over every slot
// initialises the table; no request is taken until it ends. An allocate walks the buddy tree
// leftmost-first: it descends level by level, reads and tests each tried leaf, backtracks to
// a right half when a leaf fails, and on the way back reads each level's midpoint entry and
// writes the split right half there unless it is in use. A free finds its slot with a shift,
// then each merged level takes one run of a bit-serial divider for the buddy parity (one
// quotient bit per bit of a table entry) and the table reads and writes of the merge states.
// Every request gives one result; the next request is accepted as soon as the previous result
// sits in the output register.
module buddy_allocator_core #(
   parameter int NUM_SLOTS = ba_pkg::NUM_SLOTS_DEF,
   parameter int MIN_BLOCK = ba_pkg::MIN_BLOCK_DEF,
   parameter int MAX_BLOCK = ba_pkg::MAX_BLOCK_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   ba_req_if.sink                        req_ch,
   ba_rsp_if.source                      rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ba_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ba_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ba_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);

   localparam int HEAP_BYTES = NUM_SLOTS * MIN_BLOCK;
   localparam int TOP_BYTES  = (MAX_BLOCK > HEAP_BYTES) ? MAX_BLOCK : HEAP_BYTES;
   localparam int ENT_W      = $clog2(TOP_BYTES) + 2;
   localparam int SLOT_W     = $clog2(NUM_SLOTS);
   localparam int N_W        = $clog2(NUM_SLOTS + 1);
   localparam int SD         = SLOT_W + 1;
   localparam int SP_W       = $clog2(SD + 1);
   localparam int IDX_W      = $clog2(SD);
   localparam int CNT_W      = $clog2(ENT_W + 1);
   localparam int MB_SH      = $clog2(MIN_BLOCK);

   localparam logic [31:0]      MINB      = 32'(MIN_BLOCK);
   localparam logic [31:0]      HEAP32    = 32'(HEAP_BYTES);
   localparam logic [ENT_W-1:0] MIN_ENT   = ENT_W'(MIN_BLOCK);
   localparam logic [ENT_W-1:0] MAX_ENT   = ENT_W'(MAX_BLOCK);
   localparam logic [ENT_W:0]   NUM_WIDE  = (ENT_W + 1)'(NUM_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [N_W-1:0]   NUM_N     = N_W'(NUM_SLOTS);

   ba_pkg::state_type state_ff, state_in;

   logic [31:0]       heap_base_ff;
   logic [ENT_W-1:0]  size_ff, size_in;
   logic [31:0]       faddr_ff, faddr_in;
   logic [SLOT_W-1:0] lo_ff, lo_in;
   logic [N_W-1:0]    n_ff, n_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] buddy_ff, buddy_in;
   logic [ENT_W-1:0]  msize_ff, msize_in;
   logic [ENT_W-1:0]  disp_ff, disp_in;
   logic              par_ff, par_in;
   logic              first_ff, first_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic              res_ok_ff, res_ok_in;
   logic [31:0]       res_addr_ff, res_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [31:0]       rsp_addr_ff, rsp_addr_in;

   logic [SLOT_W-1:0] stk_lo_ff [SD];
   logic [N_W-1:0]    stk_n_ff [SD];
   logic              push;

   logic [ENT_W-1:0]  mem [NUM_SLOTS];
   logic [ENT_W-1:0]  rd_data_ff;
   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   logic [ENT_W-1:0]  mem_wdata;
   logic [SLOT_W-1:0] mem_raddr;

   logic [ENT_W-1:0]  dvd_ff, dvd_in;
   logic [ENT_W-1:0]  rem_ff, rem_in;
   logic [ENT_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]  dcnt_ff, dcnt_in;
   logic              div_start;
   logic [ENT_W-1:0]  div_dividend;
   logic [ENT_W-1:0]  div_divisor;
   logic [ENT_W:0]    div_trial;
   logic              div_ge;
   logic              div_done;

   logic              req_fire;
   logic              rsp_free;
   logic [N_W-1:0]    half;
   logic [31:0]       half_bytes;
   logic [31:0]       whole_bytes;
   logic              fits_half;
   logic [ENT_W-1:0]  e_size;
   logic              leaf_ok;
   logic [IDX_W-1:0]  top_idx;
   logic [SLOT_W-1:0] top_lo;
   logic [N_W-1:0]    top_n;
   logic [N_W-1:0]    top_half;
   logic [SLOT_W-1:0] top_mid;
   logic [31:0]       off;
   logic              off_ok;
   logic [SLOT_W-1:0] off_slot;
   logic [ENT_W-1:0]  m_disp;
   logic [ENT_W:0]    bsum;
   logic              hi_bad;
   logic              lo_bad;
   logic              bud_match;
   logic              csr_wr;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == ba_pkg::REG_HEAP_BASE) ? heap_base_ff : '0;

   // Handshakes.
   assign req_ch.ready         = (state_ff == ba_pkg::ST_IDLE);
   assign req_fire             = req_ch.valid && req_ch.ready;
   assign rsp_free             = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.ok            = rsp_ok_ff;
   assign rsp_ch.block_address = rsp_addr_ff;

   // Tree walk terms.
   assign half        = n_ff >> 1;
   assign half_bytes  = 32'(half) * MINB;
   assign whole_bytes = 32'(n_ff) * MINB;
   assign fits_half   = 32'(size_ff) <= half_bytes;
   assign e_size      = {rd_data_ff[ENT_W-1:1], 1'b0};
   assign leaf_ok     = !rd_data_ff[0] && (32'(rd_data_ff) >= whole_bytes);
   assign top_idx     = IDX_W'(sp_ff - SP_W'(1));
   assign top_lo      = stk_lo_ff[top_idx];
   assign top_n       = stk_n_ff[top_idx];
   assign top_half    = top_n >> 1;
   assign top_mid     = top_lo + SLOT_W'(top_half);

   // Free and merge terms. The offset must be in range and a whole number of slots.
   assign off       = faddr_ff - heap_base_ff;
   assign off_ok    = (off < HEAP32) && (off[MB_SH-1:0] == '0);
   assign off_slot  = SLOT_W'(off >> MB_SH);
   assign m_disp    = e_size >> MB_SH;
   assign bsum      = {1'b0, ENT_W'(slot_ff)} + {1'b0, disp_ff};
   assign hi_bad    = bsum >= NUM_WIDE;
   assign lo_bad    = ENT_W'(slot_ff) < disp_ff;
   assign bud_match = !rd_data_ff[0] && (e_size == msize_ff);

   // Bit-serial restoring divider for the buddy parity, one quotient bit a cycle.
   assign div_trial = {rem_ff, dvd_ff[ENT_W-1]};
   assign div_ge    = div_trial >= {1'b0, dvs_ff};
   assign div_done  = (dcnt_ff == '0);

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dcnt_in = dcnt_ff;
      if (div_start) begin
         dvd_in  = div_dividend;
         rem_in  = '0;
         dvs_in  = div_divisor;
         dcnt_in = CNT_W'(ENT_W);
      end else if (!div_done) begin
         dvd_in  = {dvd_ff[ENT_W-2:0], div_ge};
         rem_in  = div_ge ? ENT_W'(div_trial - {1'b0, dvs_ff}) : ENT_W'(div_trial);
         dcnt_in = dcnt_ff - CNT_W'(1);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ba_pkg::ST_CLR: begin
            if (clr_ff == LAST_SLOT) begin
               state_in = ba_pkg::ST_IDLE;
            end
         end
         ba_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.req_type == ba_pkg::OP_FREE) begin
                  state_in = ba_pkg::ST_F_CHK;
               end else if (32'(req_ch.req_size) > 32'(MAX_BLOCK)) begin
                  state_in = ba_pkg::ST_DONE;
               end else begin
                  state_in = ba_pkg::ST_A_DESC;
               end
            end
         end
         ba_pkg::ST_A_DESC: begin
            if (!fits_half) begin
               state_in = ba_pkg::ST_A_LEAF;
            end
         end
         ba_pkg::ST_A_LEAF: begin
            if (leaf_ok) begin
               state_in = ba_pkg::ST_A_UNW;
            end else if (sp_ff == '0) begin
               state_in = ba_pkg::ST_DONE;
            end else begin
               state_in = ba_pkg::ST_A_DESC;
            end
         end
         ba_pkg::ST_A_UNW: begin
            state_in = (sp_ff == '0) ? ba_pkg::ST_DONE : ba_pkg::ST_A_FIX;
         end
         ba_pkg::ST_A_FIX: begin
            state_in = ba_pkg::ST_A_UNW;
         end
         ba_pkg::ST_F_CHK: begin
            state_in = off_ok ? ba_pkg::ST_M_SIZE : ba_pkg::ST_DONE;
         end
         ba_pkg::ST_M_SIZE: begin
            if (first_ff && !rd_data_ff[0]) begin
               state_in = ba_pkg::ST_DONE;
            end else if (m_disp == '0) begin
               state_in = ba_pkg::ST_DONE;
            end else begin
               state_in = ba_pkg::ST_M_PAR;
            end
         end
         ba_pkg::ST_M_PAR: begin
            if (div_done) begin
               if ((!dvd_ff[0] && hi_bad) || (dvd_ff[0] && lo_bad)) begin
                  state_in = ba_pkg::ST_DONE;
               end else begin
                  state_in = ba_pkg::ST_M_BUD;
               end
            end
         end
         ba_pkg::ST_M_BUD: begin
            state_in = bud_match ? ba_pkg::ST_M_W2 : ba_pkg::ST_DONE;
         end
         ba_pkg::ST_M_W2: begin
            state_in = ba_pkg::ST_M_RD;
         end
         ba_pkg::ST_M_RD: begin
            state_in = ba_pkg::ST_M_SIZE;
         end
         ba_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = ba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ba_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and table controls.
   always_comb begin
      size_in      = size_ff;
      faddr_in     = faddr_ff;
      lo_in        = lo_ff;
      n_in         = n_ff;
      sp_in        = sp_ff;
      slot_in      = slot_ff;
      buddy_in     = buddy_ff;
      msize_in     = msize_ff;
      disp_in      = disp_ff;
      par_in       = par_ff;
      first_in     = first_ff;
      clr_in       = clr_ff;
      res_ok_in    = res_ok_ff;
      res_addr_in  = res_addr_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      push         = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = slot_ff;
      mem_wdata    = '0;
      mem_raddr    = slot_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = MIN_ENT;
      case (state_ff)
         ba_pkg::ST_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = (clr_ff == '0) ? MAX_ENT : '0;
            clr_in    = clr_ff + SLOT_W'(1);
         end
         ba_pkg::ST_IDLE: begin
            if (req_fire) begin
               faddr_in    = req_ch.free_address;
               size_in     = (32'(req_ch.req_size) < MINB) ? MIN_ENT
                                                           : ENT_W'(req_ch.req_size);
               lo_in       = '0;
               n_in        = NUM_N;
               sp_in       = '0;
               res_ok_in   = 1'b0;
               res_addr_in = '0;
            end
         end
         ba_pkg::ST_A_DESC: begin
            if (fits_half) begin
               push  = 1'b1;
               sp_in = sp_ff + SP_W'(1);
               n_in  = half;
            end else begin
               mem_raddr = lo_ff;
            end
         end
         ba_pkg::ST_A_LEAF: begin
            if (leaf_ok) begin
               mem_we      = 1'b1;
               mem_waddr   = lo_ff;
               mem_wdata   = ENT_W'(whole_bytes) | ENT_W'(1);
               res_ok_in   = 1'b1;
               res_addr_in = heap_base_ff + 32'(lo_ff) * MINB;
            end else if (sp_ff != '0) begin
               // Left half of the node on top of the stack failed: try its right half.
               lo_in = top_mid;
               n_in  = top_n - top_half;
               sp_in = sp_ff - SP_W'(1);
            end
         end
         ba_pkg::ST_A_UNW: begin
            mem_raddr = top_mid;
         end
         ba_pkg::ST_A_FIX: begin
            // The split writes the free right half at the midpoint unless it is in use.
            if (!rd_data_ff[0]) begin
               mem_we    = 1'b1;
               mem_waddr = top_mid;
               mem_wdata = ENT_W'(32'(top_half) * MINB);
            end
            sp_in = sp_ff - SP_W'(1);
         end
         ba_pkg::ST_F_CHK: begin
            slot_in   = off_slot;
            mem_raddr = off_slot;
            first_in  = 1'b1;
         end
         ba_pkg::ST_M_SIZE: begin
            first_in = 1'b0;
            if (!(first_ff && !rd_data_ff[0])) begin
               if (first_ff) begin
                  res_ok_in   = 1'b1;
                  res_addr_in = faddr_ff;
               end
               mem_we    = 1'b1;
               mem_waddr = slot_ff;
               mem_wdata = e_size;
               msize_in  = e_size;
               disp_in   = m_disp;
               if (m_disp != '0) begin
                  div_start    = 1'b1;
                  div_dividend = ENT_W'(slot_ff);
                  div_divisor  = m_disp;
               end
            end
         end
         ba_pkg::ST_M_PAR: begin
            par_in = dvd_ff[0];
            if (dvd_ff[0]) begin
               buddy_in  = slot_ff - SLOT_W'(disp_ff);
               mem_raddr = slot_ff - SLOT_W'(disp_ff);
            end else begin
               buddy_in  = SLOT_W'(bsum);
               mem_raddr = SLOT_W'(bsum);
            end
         end
         ba_pkg::ST_M_BUD: begin
            if (bud_match) begin
               mem_we    = 1'b1;
               mem_waddr = par_ff ? slot_ff : buddy_ff;
               mem_wdata = '0;
            end
         end
         ba_pkg::ST_M_W2: begin
            mem_we    = 1'b1;
            mem_waddr = par_ff ? buddy_ff : slot_ff;
            mem_wdata = ENT_W'({msize_ff, 1'b0});
            if (par_ff) begin
               slot_in = buddy_ff;
            end
         end
         ba_pkg::ST_M_RD: begin
            mem_raddr = slot_ff;
         end
         ba_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_addr_in  = res_ok_ff ? res_addr_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ba_pkg::ST_CLR;
         clr_ff       <= '0;
         sp_ff        <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         heap_base_ff <= ba_pkg::HEAP_BASE_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr && csr_paddr[2] == ba_pkg::REG_HEAP_BASE) begin
            heap_base_ff <= csr_pwdata;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      size_ff     <= size_in;
      faddr_ff    <= faddr_in;
      lo_ff       <= lo_in;
      n_ff        <= n_in;
      slot_ff     <= slot_in;
      buddy_ff    <= buddy_in;
      msize_ff    <= msize_in;
      disp_ff     <= disp_in;
      par_ff      <= par_in;
      first_ff    <= first_in;
      res_ok_ff   <= res_ok_in;
      res_addr_ff <= res_addr_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_addr_ff <= rsp_addr_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      if (push) begin
         stk_lo_ff[sp_ff[IDX_W-1:0]] <= lo_ff;
         stk_n_ff[sp_ff[IDX_W-1:0]]  <= n_ff;
      end
   end

   // Block table.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   assert property (@(posedge clock) disable iff (reset) sp_ff <= SP_W'(SD))
      else $error("search stack overflow");

   assert property (@(posedge clock) disable iff (reset) div_start |-> div_done)
      else $error("divider restarted while busy");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ba_pkg::ST_DONE))
      else $error("result presented without a finished request");

   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ba_pkg::ST_IDLE)
      else $error("request transfer did not start work");

   assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff == ba_pkg::ST_A_LEAF) |-> mem_wdata[0])
      else $error("allocated block not marked used");

endmodule
